// ===== design/stsr_pkg.sv =====
// shared constants, codes and types of the sorted table core
package stsr_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = 6;
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAPACITY);

   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic signed [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0]        raddr;
   } mem_req_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } cmp_res_type;

endpackage

// ===== design/sorted_table_insert_search_remove_core.sv =====
// top level of the sorted table core: sequencer, comparator and table storage
// Keeps up to 64 signed 32-bit entries in ascending order in a registered-read
// memory, walked by one comparator under a small sequencer. An item is taken
// when start is high and busy is low; busy then stays high until the last
// result is issued (a full insert or an empty dump never raises busy).
// Results appear for one cycle with rsp_valid and cannot be held off. Every
// table access is an address, then registered data. An insert compares from
// the top down and moves each larger entry up one place, with a separate
// write step when the value lands at index 0; a search probes by halving (at
// most 7 probes for 64 entries); a remove searches, then moves each later
// entry down one place; a dump reads and issues one result per entry. An
// empty dump or a full insert answers in the cycle after the transfer. The
// capacity register is written whenever csr_valid is high; write it only
// while the core is idle.
module sorted_table_insert_search_remove_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic signed [stsr_pkg::DATA_W-1:0] req_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stsr_pkg::CNT_W-1:0]         csr_data,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [stsr_pkg::ADDR_W-1:0]        rsp_position,
   output logic signed [stsr_pkg::DATA_W-1:0] rsp_element,
   output logic [stsr_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                               rsp_last
);
   import stsr_pkg::*;

   mem_req_type              mem_req;
   logic signed [DATA_W-1:0] rdata;
   logic signed [DATA_W-1:0] cmp_key;
   cmp_res_type              cmp_res;

   assign csr_ready = 1'b1;

   stsr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .mem_req         (mem_req),
      .rdata           (rdata),
      .cmp_key         (cmp_key),
      .cmp_res         (cmp_res),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_element     (rsp_element),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   stsr_cmp u_cmp (
      .probe (rdata),
      .key   (cmp_key),
      .res   (cmp_res)
   );

   stsr_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

endmodule

// ===== design/stsr_ram.sv =====
// single-port-write, registered-read table storage
module stsr_ram (
   input  logic                             clock,
   input  stsr_pkg::mem_req_type            mem_req,
   output logic signed [stsr_pkg::DATA_W-1:0] rdata
);
   import stsr_pkg::*;

   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/stsr_cmp.sv =====
// shared two's-complement signed comparator for probe and shift decisions
module stsr_cmp (
   input  logic signed [stsr_pkg::DATA_W-1:0] probe,
   input  logic signed [stsr_pkg::DATA_W-1:0] key,
   output stsr_pkg::cmp_res_type              res
);
   import stsr_pkg::*;

   always_comb begin
      res.lt = probe < key;
      res.eq = probe == key;
      res.gt = probe > key;
   end

endmodule

// ===== design/stsr_ctrl.sv =====
// sequencer: insert shift, binary search, remove shift and dump walk
module stsr_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic signed [stsr_pkg::DATA_W-1:0] req_value,
   input  logic                               csr_valid,
   input  logic [stsr_pkg::CNT_W-1:0]         csr_data,
   output stsr_pkg::mem_req_type              mem_req,
   input  logic signed [stsr_pkg::DATA_W-1:0] rdata,
   output logic signed [stsr_pkg::DATA_W-1:0] cmp_key,
   input  stsr_pkg::cmp_res_type              cmp_res,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [stsr_pkg::ADDR_W-1:0]        rsp_position,
   output logic signed [stsr_pkg::DATA_W-1:0] rsp_element,
   output logic [stsr_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                               rsp_last
);
   import stsr_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_RD   = 4'd1;
   localparam logic [3:0] S_INS_CMP  = 4'd2;
   localparam logic [3:0] S_INS_PUT  = 4'd3;
   localparam logic [3:0] S_SRCH     = 4'd4;
   localparam logic [3:0] S_SRCH_CMP = 4'd5;
   localparam logic [3:0] S_REM_RD   = 4'd6;
   localparam logic [3:0] S_REM_WR   = 4'd7;
   localparam logic [3:0] S_DUMP_RD  = 4'd8;
   localparam logic [3:0] S_DUMP_OUT = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hip_ff, hip_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic signed [DATA_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]         limit;
   logic [CNT_W-1:0]         idx_m1;
   logic [CNT_W-1:0]         idx_p1;
   logic [CNT_W:0]           mid_sum;

   assign limit   = (cap_ff > CAP_RESET) ? CAP_RESET : cap_ff;
   assign idx_m1  = idx_ff - CNT_W'(1);
   assign idx_p1  = idx_ff + CNT_W'(1);
   // floor midpoint of lo and hi-1, with hi kept as an exclusive bound
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip_ff} - (CNT_W+1)'(1);
   assign busy    = state_ff != S_IDLE;
   assign cmp_key = val_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      cap_in        = csr_valid ? csr_data : cap_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hip_in        = hip_ff;
      mid_in        = mid_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff[ADDR_W-1:0];
      mem_req.wdata = val_ff;
      mem_req.raddr = idx_ff[ADDR_W-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_elem_in   = val_ff;
      rsp_count_in  = count_ff;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_opcode;
               val_in = req_value;
               idx_in = count_ff;
               lo_in  = '0;
               hip_in = count_ff;
               unique case (req_opcode)
                  OP_INSERT: begin
                     if (count_ff >= limit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_elem_in   = req_value;
                     end else if (count_ff == '0) begin
                        state_in = S_INS_PUT;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_SEARCH, OP_REMOVE: begin
                     state_in = S_SRCH;
                  end
                  OP_DUMP: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_elem_in   = '0;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INS_RD: begin
            mem_req.raddr = idx_m1[ADDR_W-1:0];
            state_in      = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (cmp_res.gt) begin
               // move the larger neighbor up one place
               mem_req.we    = 1'b1;
               mem_req.wdata = rdata;
               idx_in        = idx_m1;
               state_in      = (idx_ff == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               mem_req.we    = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = idx_ff[ADDR_W-1:0];
               rsp_count_in  = count_ff + CNT_W'(1);
               state_in      = S_IDLE;
            end
         end
         S_INS_PUT: begin
            mem_req.we   = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_pos_in   = idx_ff[ADDR_W-1:0];
            rsp_count_in = count_ff + CNT_W'(1);
            state_in     = S_IDLE;
         end
         S_SRCH: begin
            if (lo_ff < hip_ff) begin
               mid_in        = mid_sum[ADDR_W:1];
               mem_req.raddr = mid_sum[ADDR_W:1];
               state_in      = S_SRCH_CMP;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end
         end
         S_SRCH_CMP: begin
            if (cmp_res.eq) begin
               idx_in = {1'b0, mid_ff};
               if (op_ff == OP_REMOVE && ({1'b0, mid_ff} + CNT_W'(1)) < count_ff) begin
                  state_in = S_REM_RD;
               end else begin
                  if (op_ff == OP_REMOVE) begin
                     count_in     = count_ff - CNT_W'(1);
                     rsp_count_in = count_ff - CNT_W'(1);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = mid_ff;
                  state_in     = S_IDLE;
               end
            end else if (cmp_res.lt) begin
               lo_in    = {1'b0, mid_ff} + CNT_W'(1);
               state_in = S_SRCH;
            end else begin
               hip_in   = {1'b0, mid_ff};
               state_in = S_SRCH;
            end
         end
         S_REM_RD: begin
            mem_req.raddr = idx_p1[ADDR_W-1:0];
            state_in      = S_REM_WR;
         end
         S_REM_WR: begin
            // close the gap one entry at a time
            mem_req.we    = 1'b1;
            mem_req.wdata = rdata;
            idx_in        = idx_p1;
            if ((idx_p1 + CNT_W'(1)) < count_ff) begin
               state_in = S_REM_RD;
            end else begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_pos_in   = mid_ff;
               rsp_count_in = count_ff - CNT_W'(1);
               state_in     = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = idx_ff[ADDR_W-1:0];
            rsp_elem_in  = rdata;
            rsp_last_in  = idx_p1 == count_ff;
            idx_in       = idx_p1;
            state_in     = (idx_p1 == count_ff) ? S_IDLE : S_DUMP_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      hip_ff        <= hip_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_element     = rsp_elem_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== design/stsr_checker.sv =====
// port-level checks on the sorted table core, bound to the top level
module stsr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic [stsr_pkg::ADDR_W-1:0]        rsp_position,
   input logic [stsr_pkg::CNT_W-1:0]         rsp_entry_count,
   input logic                               rsp_last
);
   import stsr_pkg::*;

   // a dump result that is not the last keeps the core busy for the rest
   a_more_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> busy)
      else $error("core went idle in the middle of a dump");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error status on a result that is not the last");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0 && rsp_position == '0)
      else $error("empty status with entries present");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |->
         ({1'b0, rsp_position} < rsp_entry_count) || rsp_entry_count == '0 ||
         ({1'b0, rsp_position} == rsp_entry_count))
      else $error("position beyond the table");

endmodule

bind sorted_table_insert_search_remove_core stsr_checker u_stsr_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_entry_count (rsp_entry_count),
   .rsp_last        (rsp_last)
);
